// ===== sv/xzrd_pkg.sv =====
// Shared types and constants for the XOR zero-run diff encoder.
`timescale 1ns / 1ps
`default_nettype none
package xzrd_pkg;

   localparam int unsigned RUN_W = 16;
   localparam int unsigned LEN_W = 17;
   localparam int unsigned NUM_SLOTS = 8;
   localparam int unsigned SLOT_IDX_W = 3;

   localparam logic [RUN_W-1:0] RUN_SPLIT = 16'h8000;
   localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;
   localparam logic [LEN_W-1:0] LEN_MAX = 17'h1FFFF;
   localparam logic [7:0] SPLIT_FILL = 8'hFF;
   localparam logic [14:0] SHORT_RUN_MAX = 15'h007F;

   // Fixed positions of the words an input can produce, in emission order.
   localparam logic [SLOT_IDX_W-1:0] SLOT_SPLIT_MARK = 3'd0;
   localparam logic [SLOT_IDX_W-1:0] SLOT_SPLIT_LO = 3'd1;
   localparam logic [SLOT_IDX_W-1:0] SLOT_SPLIT_HI = 3'd2;
   localparam logic [SLOT_IDX_W-1:0] SLOT_RUN_MARK = 3'd3;
   localparam logic [SLOT_IDX_W-1:0] SLOT_RUN_LO = 3'd4;
   localparam logic [SLOT_IDX_W-1:0] SLOT_RUN_HI = 3'd5;
   localparam logic [SLOT_IDX_W-1:0] SLOT_XOR = 3'd6;
   localparam logic [SLOT_IDX_W-1:0] SLOT_BARE = 3'd7;

   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

endpackage
`default_nettype wire

// ===== sv/xor_zero_run_diff_encoder_core.sv =====
// XOR zero-run diff encoder: byte-pair input, diff stream output.
//
// Each accepted byte pair is XORed; zero results grow a run counter, a
// nonzero result queues the run code (0,FF,FF for runs over 32768, then 0
// and run-1 in one or two bytes) ahead of the XOR byte. A pending register
// holds the words an input produces as a slot mask and hands one word per
// cycle to the output register while rsp_ready does not stall it (zero
// bytes that are not block end produce nothing); a new pair is taken in
// the same cycle the previous item's final word moves to the output
// register. rsp_byte_count counts bytes per block and both counters clear
// at block end. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module xor_zero_run_diff_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_cur_byte,
   input  wire logic [7:0]  req_prev_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_diff_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_run_last,
   output logic             rsp_block_end,
   output logic [16:0]      rsp_byte_count
);

   // pending item
   xzrd_pkg::slot_mask_type mask_ff, mask_in;
   logic [7:0] run_lo_ff, run_lo_in;
   logic [7:0] run_hi_ff, run_hi_in;
   logic [7:0] xor_ff, xor_in;
   logic       last_ff, last_in;

   // block state
   logic [xzrd_pkg::RUN_W-1:0] run_cnt_ff, run_cnt_in;
   logic [xzrd_pkg::LEN_W-1:0] emit_cnt_ff, emit_cnt_in;

   // output register
   logic        out_vld_ff, out_vld_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_bvld_ff, out_bvld_in;
   logic        out_rlast_ff, out_rlast_in;
   logic        out_bend_ff, out_bend_in;
   logic [xzrd_pkg::LEN_W-1:0] out_len_ff, out_len_in;

   logic [7:0]  x;
   logic        accept;
   logic        load;
   logic        out_free;
   logic        emit;
   logic        is_final;
   logic [xzrd_pkg::SLOT_IDX_W-1:0] sel_idx;
   xzrd_pkg::slot_mask_type mask_next;
   xzrd_pkg::slot_mask_type new_mask;
   logic        split;
   logic [xzrd_pkg::RUN_W-1:0] j_run;
   logic        run_en;
   logic [14:0] j_minus;
   logic        two_bytes;
   logic [7:0]  sel_byte;
   logic        sel_bvld;
   logic [xzrd_pkg::LEN_W-1:0] cnt_next;

   assign x = req_cur_byte ^ req_prev_byte;

   // run code for the pending zero run; a zero block end drops the run
   always_comb begin
      split = run_cnt_ff > xzrd_pkg::RUN_SPLIT;
      j_run = split ? (run_cnt_ff - xzrd_pkg::RUN_SPLIT) : run_cnt_ff;
      run_en = j_run != '0;
      j_minus = 15'(j_run - 16'd1);
      two_bytes = j_minus > xzrd_pkg::SHORT_RUN_MAX;
      new_mask = '0;
      new_mask[xzrd_pkg::SLOT_SPLIT_MARK] = split && (x != 8'h00);
      new_mask[xzrd_pkg::SLOT_SPLIT_LO] = split && (x != 8'h00);
      new_mask[xzrd_pkg::SLOT_SPLIT_HI] = split && (x != 8'h00);
      new_mask[xzrd_pkg::SLOT_RUN_MARK] = run_en && (x != 8'h00);
      new_mask[xzrd_pkg::SLOT_RUN_LO] = run_en && (x != 8'h00);
      new_mask[xzrd_pkg::SLOT_RUN_HI] = run_en && two_bytes && (x != 8'h00);
      new_mask[xzrd_pkg::SLOT_XOR] = x != 8'h00;
      new_mask[xzrd_pkg::SLOT_BARE] = x == 8'h00;
   end

   // lowest pending slot goes out next
   always_comb begin
      sel_idx = '0;
      for (int i = xzrd_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel_idx = xzrd_pkg::SLOT_IDX_W'(i);
         end
      end
      mask_next = mask_ff & ~(xzrd_pkg::slot_mask_type'(1) << sel_idx);
      is_final = mask_next == '0;
   end

   always_comb begin
      sel_bvld = 1'b1;
      unique case (sel_idx)
         xzrd_pkg::SLOT_SPLIT_MARK: sel_byte = 8'h00;
         xzrd_pkg::SLOT_SPLIT_LO:   sel_byte = xzrd_pkg::SPLIT_FILL;
         xzrd_pkg::SLOT_SPLIT_HI:   sel_byte = xzrd_pkg::SPLIT_FILL;
         xzrd_pkg::SLOT_RUN_MARK:   sel_byte = 8'h00;
         xzrd_pkg::SLOT_RUN_LO:     sel_byte = run_lo_ff;
         xzrd_pkg::SLOT_RUN_HI:     sel_byte = run_hi_ff;
         xzrd_pkg::SLOT_XOR:        sel_byte = xor_ff;
         xzrd_pkg::SLOT_BARE: begin
            sel_byte = 8'h00;
            sel_bvld = 1'b0;
         end
         default:                   sel_byte = 8'h00;
      endcase
   end

   assign out_free = !out_vld_ff || rsp_ready;
   assign emit = (mask_ff != '0) && out_free;
   assign req_ready = (mask_ff == '0) || (emit && is_final);
   assign accept = req_valid && req_ready;
   assign load = accept && ((x != 8'h00) || req_last_byte);

   always_comb begin
      cnt_next = (sel_bvld && (emit_cnt_ff < xzrd_pkg::LEN_MAX)) ?
                 emit_cnt_ff + 17'd1 : emit_cnt_ff;

      // pending register
      mask_in = mask_ff;
      run_lo_in = run_lo_ff;
      run_hi_in = run_hi_ff;
      xor_in = xor_ff;
      last_in = last_ff;
      if (emit) begin
         mask_in = mask_next;
      end
      if (load) begin
         mask_in = new_mask;
         run_lo_in = two_bytes ? {1'b1, j_minus[6:0]} : j_minus[7:0];
         run_hi_in = j_minus[14:7];
         xor_in = x;
         last_in = req_last_byte;
      end

      // zero-run counter
      run_cnt_in = run_cnt_ff;
      if (accept) begin
         if (x != 8'h00 || req_last_byte) begin
            run_cnt_in = '0;
         end else if (run_cnt_ff < xzrd_pkg::RUN_MAX) begin
            run_cnt_in = run_cnt_ff + 16'd1;
         end
      end

      // output register and length counter
      emit_cnt_in = emit_cnt_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      out_byte_in = out_byte_ff;
      out_bvld_in = out_bvld_ff;
      out_rlast_in = out_rlast_ff;
      out_bend_in = out_bend_ff;
      out_len_in = out_len_ff;
      if (emit) begin
         out_vld_in = 1'b1;
         out_byte_in = sel_byte;
         out_bvld_in = sel_bvld;
         out_rlast_in = is_final;
         out_bend_in = is_final && last_ff;
         out_len_in = cnt_next;
         emit_cnt_in = (is_final && last_ff) ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         run_cnt_ff <= '0;
         emit_cnt_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         run_cnt_ff <= run_cnt_in;
         emit_cnt_ff <= emit_cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      run_lo_ff <= run_lo_in;
      run_hi_ff <= run_hi_in;
      xor_ff <= xor_in;
      last_ff <= last_in;
      out_byte_ff <= out_byte_in;
      out_bvld_ff <= out_bvld_in;
      out_rlast_ff <= out_rlast_in;
      out_bend_ff <= out_bend_in;
      out_len_ff <= out_len_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_diff_byte = out_byte_ff;
   assign rsp_byte_valid = out_bvld_ff;
   assign rsp_run_last = out_rlast_ff;
   assign rsp_block_end = out_bend_ff;
   assign rsp_byte_count = out_len_ff;

endmodule
`default_nettype wire

// ===== sim/tb_xor_zero_run_diff_encoder_core.sv =====
// Testbench for the XOR zero-run diff encoder core: directed, run-length and random checks.
`timescale 1ns / 1ps
module tb_xor_zero_run_diff_encoder_core;

   typedef struct packed {
      logic [7:0]                 diff_byte;
      logic                       byte_valid;
      logic                       run_last;
      logic                       block_end;
      logic [xzrd_pkg::LEN_W-1:0] byte_count;
   } diff_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_cur_byte;
   logic [7:0]  req_prev_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_diff_byte;
   logic        rsp_byte_valid;
   logic        rsp_run_last;
   logic        rsp_block_end;
   logic [16:0] rsp_byte_count;

   xor_zero_run_diff_encoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cur_byte    (req_cur_byte),
      .req_prev_byte   (req_prev_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_diff_byte   (rsp_diff_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_block_end   (rsp_block_end),
      .rsp_byte_count  (rsp_byte_count)
   );

   // predictor state
   logic [xzrd_pkg::RUN_W-1:0] pend_zeros;
   logic [xzrd_pkg::LEN_W-1:0] diff_count;
   diff_word_type              expected_words[$];
   diff_word_type              word_buf[0:6];
   int                         word_n;

   int  err_count;
   int  pairs_sent;
   bit  idle_on;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #10_000_000;
      $display("tb_xor_zero_run_diff_encoder_core: done, errors");
      $finish;
   end

   task automatic push_byte(input logic [7:0] value, input logic valid);
      if (valid && diff_count != xzrd_pkg::LEN_MAX)
         diff_count++;
      word_buf[word_n].diff_byte   = valid ? value : 8'h00;
      word_buf[word_n].byte_valid  = valid;
      word_buf[word_n].run_last    = 1'b0;
      word_buf[word_n].block_end   = 1'b0;
      word_buf[word_n].byte_count  = diff_count;
      word_n++;
   endtask

   // Expected diff words for one accepted byte pair.
   task automatic predict_pair(input logic [7:0] cur, input logic [7:0] prev,
                               input logic last);
      logic [7:0]                 x;
      logic [xzrd_pkg::RUN_W-1:0] run;
      x = cur ^ prev;
      word_n = 0;
      if (x == 8'h00) begin
         if (pend_zeros != xzrd_pkg::RUN_MAX)
            pend_zeros++;
         if (!last)
            return;
         push_byte(8'h00, 1'b0);
      end else begin
         run = pend_zeros;
         if (run > xzrd_pkg::RUN_SPLIT) begin
            push_byte(8'h00, 1'b1);
            push_byte(xzrd_pkg::SPLIT_FILL, 1'b1);
            push_byte(xzrd_pkg::SPLIT_FILL, 1'b1);
            run = run - xzrd_pkg::RUN_SPLIT;
         end
         if (run != '0) begin
            push_byte(8'h00, 1'b1);
            run = run - 16'd1;
            if (run <= {1'b0, xzrd_pkg::SHORT_RUN_MAX}) begin
               push_byte(run[7:0], 1'b1);
            end else begin
               push_byte({1'b1, run[6:0]}, 1'b1);
               push_byte(run[14:7], 1'b1);
            end
         end
         pend_zeros = '0;
         push_byte(x, 1'b1);
      end
      word_buf[word_n-1].run_last = 1'b1;
      if (last) begin
         word_buf[word_n-1].block_end = 1'b1;
         pend_zeros = '0;
         diff_count = '0;
      end
      for (int i = 0; i < word_n; i++)
         expected_words.push_back(word_buf[i]);
   endtask

   task automatic send_pair(input logic [7:0] cur, input logic [7:0] prev,
                            input logic last);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 10)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cur_byte  <= cur;
      req_prev_byte <= prev;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pair(cur, prev, last);
      pairs_sent++;
   endtask

   task automatic send_zero(input logic last);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      send_pair(b, b, last);
   endtask

   task automatic send_nonzero(input logic last);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'($urandom_range(0, 255));
      x = 8'($urandom_range(1, 255));
      send_pair(p ^ x, p, last);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      err_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
   endtask

   // result checker
   always @(posedge clock) begin : check_words
      diff_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            err_count++;
            $display("%0t: unexpected word: expected none, got byte %0h len %0h",
                     $time, rsp_diff_byte, rsp_byte_count);
         end else begin
            want = expected_words.pop_front();
            if (rsp_diff_byte !== want.diff_byte)
               note_mismatch("diff_byte", 32'(want.diff_byte), 32'(rsp_diff_byte));
            if (rsp_byte_valid !== want.byte_valid)
               note_mismatch("byte_valid", 32'(want.byte_valid), 32'(rsp_byte_valid));
            if (rsp_run_last !== want.run_last)
               note_mismatch("run_last", 32'(want.run_last), 32'(rsp_run_last));
            if (rsp_block_end !== want.block_end)
               note_mismatch("block_end", 32'(want.block_end), 32'(rsp_block_end));
            if (rsp_byte_count !== want.byte_count)
               note_mismatch("byte_count", 32'(want.byte_count), 32'(rsp_byte_count));
         end
      end
   end

   // result side back-pressure, one draw per word
   initial begin : drive_rsp_ready
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? int'($urandom_range(0, 10)) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic test_directed;
      idle_on = 1'b1;
      send_pair(8'h00, 8'hFF, 1'b0);
      send_pair(8'hFF, 8'h00, 1'b0);
      send_pair(8'hA5, 8'h5A, 1'b0);
      send_pair(8'h01, 8'h00, 1'b0);
      send_pair(8'h80, 8'h00, 1'b0);
      send_pair(8'h00, 8'h00, 1'b0);
      send_pair(8'hFF, 8'hFF, 1'b0);
      send_pair(8'h12, 8'h34, 1'b0);
      send_pair(8'h55, 8'hAA, 1'b1);
      // block of one zero pair: bare end, zero length
      send_pair(8'h3C, 8'h3C, 1'b1);
      // trailing run is dropped
      send_pair(8'h7F, 8'h00, 1'b0);
      send_pair(8'h00, 8'h00, 1'b0);
      send_pair(8'h66, 8'h66, 1'b0);
      send_pair(8'hFF, 8'hFF, 1'b1);
      send_pair(8'hFE, 8'h01, 1'b1);
      send_pair(8'h00, 8'h00, 1'b0);
      send_pair(8'hC3, 8'h00, 1'b1);
   endtask

   // short zero runs ahead of a nonzero byte
   task automatic test_run_lengths;
      int runs[] = '{1, 2, 5};
      idle_on = 1'b0;
      foreach (runs[i]) begin
         for (int k = 0; k < runs[i]; k++)
            send_zero(1'b0);
         send_nonzero(i == runs.size() - 1);
      end
   endtask

   task automatic test_random_blocks;
      int len;
      bit last;
      while (pairs_sent < 100) begin
         idle_on = ($urandom_range(0, 3) != 0);
         len = int'($urandom_range(1, 12));
         for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            if ($urandom_range(0, 9) < 4) begin
               send_zero(last);
            end else begin
               send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), last);
            end
         end
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cur_byte  <= 8'h00;
      req_prev_byte <= 8'h00;
      req_last_byte <= 1'b0;
      pend_zeros = '0;
      diff_count = '0;
      err_count  = 0;
      pairs_sent = 0;
      idle_on    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_run_lengths();
      test_random_blocks();

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_words.size() != 0) begin
         err_count++;
         $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      end

      if (err_count == 0)
         $display("tb_xor_zero_run_diff_encoder_core: done, clean");
      else
         $display("tb_xor_zero_run_diff_encoder_core: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/xzrd_pkg.sv
sv/xor_zero_run_diff_encoder_core.sv
sim/tb_xor_zero_run_diff_encoder_core.sv
